>>> sv/pcr_pkg.sv
// Shared types and constants for the periodic Catmull-Rom evaluator.
`default_nettype none
package pcr_pkg;
    localparam int PER_W  = 36;   // loop period and knot time width
    localparam int TIME_W = 40;   // signed width of extended knot times
    localparam int WIDE_W = 64;   // intermediate coordinate width
    localparam int COORD_W = 32;

    localparam logic [WIDE_W-1:0] WIDE_LIM = 64'h2000_0000_0000_0000;

    typedef logic [1:0] req_t;
    localparam req_t REQ_CLEAR  = 2'd0;
    localparam req_t REQ_APPEND = 2'd1;
    localparam req_t REQ_EVAL   = 2'd2;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;
    localparam status_t ST_DUP   = 2'd3;
endpackage
`default_nettype wire

>>> sv/pcr_lerp.sv
// Shared interpolation unit: a + round((b - a) * num / den), shift-add then restoring divide.
`default_nettype none
module pcr_lerp
    import pcr_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic signed [WIDE_W-1:0] a,
    input  wire logic signed [WIDE_W-1:0] b,
    input  wire logic signed [TIME_W-1:0] num,
    input  wire logic signed [TIME_W-1:0] den,
    output logic                          done,
    output logic signed [WIDE_W-1:0]      y
);
    localparam int ACC_W = WIDE_W + TIME_W;

    typedef enum logic [2:0] {L_IDLE, L_MUL, L_RND, L_CHK, L_DIV, L_FIN} lstate_t;

    lstate_t                    state_reg;
    logic signed [WIDE_W-1:0]   a_reg;
    logic [WIDE_W-1:0]          ux_reg;
    logic [TIME_W-1:0]          un_reg;
    logic [TIME_W-1:0]          den_reg;
    logic                       neg_reg;
    logic [ACC_W-1:0]           acc_reg;
    logic [5:0]                 cnt_reg;
    logic [WIDE_W-1:0]          q_reg;
    logic [TIME_W:0]            rem_reg;
    logic                       done_reg;
    logic signed [WIDE_W-1:0]   y_reg;

    logic signed [WIDE_W-1:0]   diff;
    logic [WIDE_W-1:0]          lo;
    logic [TIME_W:0]            trial;
    logic                       ge;
    logic [WIDE_W-1:0]          qc;
    logic signed [WIDE_W-1:0]   sq;
    logic signed [WIDE_W-1:0]   sum;
    logic signed [WIDE_W-1:0]   lim_s;

    always_comb
    begin
        diff  = b - a;
        lo    = acc_reg[WIDE_W-1:0];
        trial = {rem_reg[TIME_W-1:0], lo[cnt_reg]};
        ge    = trial >= {1'b0, den_reg};
        qc    = (q_reg > WIDE_LIM) ? WIDE_LIM : q_reg;
        sq    = neg_reg ? -$signed(qc) : $signed(qc);
        sum   = a_reg + sq;
        lim_s = $signed(WIDE_LIM);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                L_IDLE:
                begin
                    if (start)
                    begin
                        a_reg     <= a;
                        ux_reg    <= diff[WIDE_W-1] ? -diff : diff;
                        un_reg    <= num[TIME_W-1] ? -num : num;
                        neg_reg   <= diff[WIDE_W-1] ^ num[TIME_W-1];
                        den_reg   <= den;
                        acc_reg   <= '0;
                        cnt_reg   <= 6'(TIME_W - 1);
                        state_reg <= L_MUL;
                    end
                end
                L_MUL:
                begin
                    acc_reg <= (acc_reg << 1)
                             + (un_reg[cnt_reg] ? {{TIME_W{1'b0}}, ux_reg} : '0);
                    if (cnt_reg == 6'd0)
                        state_reg <= L_RND;
                    else
                        cnt_reg <= cnt_reg - 6'd1;
                end
                L_RND:
                begin
                    acc_reg   <= acc_reg + {{WIDE_W{1'b0}}, den_reg >> 1};
                    state_reg <= L_CHK;
                end
                L_CHK:
                begin
                    // A quotient of 64 bits or more saturates straight away.
                    if (acc_reg[ACC_W-1:WIDE_W] >= den_reg)
                    begin
                        q_reg     <= WIDE_LIM;
                        state_reg <= L_FIN;
                    end
                    else
                    begin
                        rem_reg   <= {1'b0, acc_reg[ACC_W-1:WIDE_W]};
                        q_reg     <= '0;
                        cnt_reg   <= 6'(WIDE_W - 1);
                        state_reg <= L_DIV;
                    end
                end
                L_DIV:
                begin
                    rem_reg <= ge ? trial - {1'b0, den_reg} : trial;
                    q_reg   <= {q_reg[WIDE_W-2:0], ge};
                    if (cnt_reg == 6'd0)
                        state_reg <= L_FIN;
                    else
                        cnt_reg <= cnt_reg - 6'd1;
                end
                L_FIN:
                begin
                    if (sum > lim_s)
                        y_reg <= lim_s;
                    else if (sum < -lim_s)
                        y_reg <= -lim_s;
                    else
                        y_reg <= sum;
                    done_reg  <= 1'b1;
                    state_reg <= L_IDLE;
                end
                default:
                    state_reg <= L_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign y    = y_reg;
endmodule
`default_nettype wire

>>> sv/pcr_store.sv
// Control point store: knot times and coordinates, one write and one registered read port.
`default_nettype none
module pcr_store
    import pcr_pkg::*;
#(
    parameter int MAX_POINTS = 16,
    parameter int AW = 4
)
(
    input  wire logic                   clk,
    input  wire logic                   we,
    input  wire logic [AW-1:0]          waddr,
    input  wire logic [PER_W-1:0]       wknot,
    input  wire logic [3*COORD_W-1:0]   wpoint,
    input  wire logic [AW-1:0]          raddr,
    output logic [PER_W-1:0]            rknot,
    output logic [3*COORD_W-1:0]        rpoint
);
    logic [PER_W-1:0]     knot_mem [MAX_POINTS];
    logic [3*COORD_W-1:0] point_mem [MAX_POINTS];
    logic [PER_W-1:0]     rknot_reg;
    logic [3*COORD_W-1:0] rpoint_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            knot_mem[waddr]  <= wknot;
            point_mem[waddr] <= wpoint;
        end
        rknot_reg  <= knot_mem[raddr];
        rpoint_reg <= point_mem[raddr];
    end

    assign rknot  = rknot_reg;
    assign rpoint = rpoint_reg;
endmodule
`default_nettype wire

>>> sv/periodic_catmull_rom_eval.sv
// Periodic non-uniform Catmull-Rom evaluator: top level with request sequencer.
// Usage: one request item enters on the input channel (in_valid/in_ready) and
// exactly one result item leaves on the output channel (out_valid/out_ready).
// Request 0 clears the loop, 1 appends a control point with its time delta,
// 2 evaluates the curve at eval_time wrapped into [0, period).
// Clear and append give their result in the cycle after acceptance. An evaluate
// wraps the time (one remainder bit a cycle), searches the stored knots for the
// segment, fetches the four neighbouring points, then does 18 interpolations,
// each on the shared unit (40 multiply steps, then up to 64 divide steps) unless
// its interval is empty.
// Only one item is in flight; in_ready is low from acceptance until the
// result item has been taken.
// If the receiver stalls, the result is held unchanged on the output ports and
// no new item is accepted. Reset empties the loop and zeroes the period; the
// point memory itself is not cleared, as only stored entries are read.
`default_nettype none
module periodic_catmull_rom_eval
    import pcr_pkg::*;
#(
    parameter int MAX_POINTS = 16
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [1:0]                  req_type,
    input  wire logic [31:0]                 time_delta,
    input  wire logic signed [31:0]          point_x,
    input  wire logic signed [31:0]          point_y,
    input  wire logic signed [31:0]          point_z,
    input  wire logic signed [31:0]          eval_time,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic signed [31:0]               pos_x,
    output logic signed [31:0]               pos_y,
    output logic signed [31:0]               pos_z,
    output logic [1:0]                       status
);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int RW = CW + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_MOD, S_SCAN, S_SCMP, S_IXC, S_FET, S_FWAIT,
        S_TCALC, S_LSTART, S_LWAIT, S_RESP
    } state_t;

    state_t                     state_reg;
    logic [CW-1:0]              point_count_reg;
    logic [PER_W-1:0]           loop_period_reg;
    logic [PER_W-1:0]           last_knot_reg;
    status_t                    status_reg;
    logic signed [31:0]         pos_reg [3];
    logic                       tneg_reg;
    logic [31:0]                mag_reg;
    logic [PER_W:0]             rem_reg;
    logic [4:0]                 bit_reg;
    logic [PER_W-1:0]           tp_reg;
    logic [AW-1:0]              k_reg;
    logic [AW-1:0]              i1_reg;
    logic [AW-1:0]              ix_reg [4];
    logic                       wrap2_reg;
    logic                       wrap3_reg;
    logic [1:0]                 fj_reg;
    logic [3*COORD_W-1:0]       pts_reg [4];
    logic [PER_W-1:0]           kt_reg [4];
    logic signed [TIME_W-1:0]   t_reg [4];
    logic [2:0]                 step_reg;
    logic [1:0]                 axis_reg;
    logic signed [WIDE_W-1:0]   a1_reg, a2_reg, a3_reg, b1_reg, b2_reg;
    logic                       lstart_reg;

    // memory and unit connections
    logic                       st_we;
    logic [AW-1:0]              st_raddr;
    logic [PER_W-1:0]           st_rknot;
    logic [3*COORD_W-1:0]       st_rpoint;
    logic                       lu_done;
    logic signed [WIDE_W-1:0]   lu_y;

    // combinational helpers
    logic                       accept;
    logic [PER_W:0]             per_sum;
    logic [PER_W:0]             rem_trial;
    logic                       rem_ge;
    logic signed [TIME_W-1:0]   per40;
    logic signed [TIME_W-1:0]   tp40;
    logic [RW-1:0]              nn;
    logic [RW-1:0]              raw2;
    logic [RW-1:0]              raw3;
    logic signed [WIDE_W-1:0]   p [4];
    logic signed [WIDE_W-1:0]   op_a, op_b, skip_val;
    logic signed [TIME_W-1:0]   op_num, op_den;
    logic                       skip;
    logic signed [WIDE_W-1:0]   res_val;
    logic signed [31:0]         res_sat;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_RESP);
    assign st_we     = accept && (req_type == REQ_APPEND)
                     && (point_count_reg < CW'(MAX_POINTS))
                     && !((point_count_reg != '0) && (loop_period_reg == last_knot_reg));

    always_comb
    begin
        per_sum   = {1'b0, loop_period_reg} + (PER_W+1)'(time_delta);
        rem_trial = {rem_reg[PER_W-1:0], mag_reg[31]};
        rem_ge    = rem_trial >= {1'b0, loop_period_reg};
        per40     = TIME_W'(loop_period_reg);
        tp40      = TIME_W'(tp_reg);
        nn        = RW'(point_count_reg);
        raw2      = RW'(i1_reg) + RW'(1);
        raw3      = RW'(i1_reg) + RW'(2);

        case (state_reg)
            S_SCAN:  st_raddr = k_reg;
            default: st_raddr = ix_reg[fj_reg];
        endcase

        for (int j = 0; j < 4; j++)
        begin
            case (axis_reg)
                2'd0:    p[j] = WIDE_W'(signed'(pts_reg[j][COORD_W-1:0]));
                2'd1:    p[j] = WIDE_W'(signed'(pts_reg[j][2*COORD_W-1:COORD_W]));
                default: p[j] = WIDE_W'(signed'(pts_reg[j][3*COORD_W-1:2*COORD_W]));
            endcase
        end

        skip     = 1'b0;
        skip_val = p[1];
        case (step_reg)
            3'd0:
            begin
                op_a = p[0]; op_b = p[1];
                op_num = tp40 - t_reg[0]; op_den = t_reg[1] - t_reg[0];
                skip = !(t_reg[1] > t_reg[0]);
                skip_val = p[1];
            end
            3'd1:
            begin
                op_a = p[1]; op_b = p[2];
                op_num = tp40 - t_reg[1]; op_den = t_reg[2] - t_reg[1];
            end
            3'd2:
            begin
                op_a = p[2]; op_b = p[3];
                op_num = tp40 - t_reg[2]; op_den = t_reg[3] - t_reg[2];
                skip = !(t_reg[3] > t_reg[2]);
                skip_val = p[2];
            end
            3'd3:
            begin
                op_a = a1_reg; op_b = a2_reg;
                op_num = tp40 - t_reg[0]; op_den = t_reg[2] - t_reg[0];
            end
            3'd4:
            begin
                op_a = a2_reg; op_b = a3_reg;
                op_num = tp40 - t_reg[1]; op_den = t_reg[3] - t_reg[1];
            end
            default:
            begin
                op_a = b1_reg; op_b = b2_reg;
                op_num = tp40 - t_reg[1]; op_den = t_reg[2] - t_reg[1];
            end
        endcase

        res_val = (state_reg == S_LSTART) ? skip_val : lu_y;
        if (res_val > 64'sd2147483647)
            res_sat = 32'sh7FFF_FFFF;
        else if (res_val < -64'sd2147483648)
            res_sat = 32'sh8000_0000;
        else
            res_sat = res_val[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            point_count_reg <= '0;
            loop_period_reg <= '0;
            lstart_reg      <= 1'b0;
        end
        else
        begin
            lstart_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        status_reg <= ST_OK;
                        for (int j = 0; j < 3; j++)
                            pos_reg[j] <= '0;
                        state_reg <= S_RESP;
                        case (req_type)
                            REQ_CLEAR:
                            begin
                                point_count_reg <= '0;
                                loop_period_reg <= '0;
                            end
                            REQ_APPEND:
                            begin
                                if (point_count_reg >= CW'(MAX_POINTS))
                                    status_reg <= ST_FULL;
                                else
                                begin
                                    if (st_we)
                                    begin
                                        last_knot_reg   <= loop_period_reg;
                                        point_count_reg <= point_count_reg + CW'(1);
                                    end
                                    else
                                        status_reg <= ST_DUP;
                                    loop_period_reg <= per_sum[PER_W] ? '1
                                                     : per_sum[PER_W-1:0];
                                end
                            end
                            REQ_EVAL:
                            begin
                                if ((point_count_reg == '0) || (loop_period_reg == '0))
                                    status_reg <= ST_EMPTY;
                                else
                                begin
                                    tneg_reg  <= eval_time[31];
                                    mag_reg   <= eval_time[31] ? 32'(-eval_time)
                                                               : 32'(eval_time);
                                    rem_reg   <= '0;
                                    bit_reg   <= 5'd31;
                                    state_reg <= S_MOD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_MOD:
                begin
                    rem_reg <= rem_ge ? rem_trial - {1'b0, loop_period_reg} : rem_trial;
                    mag_reg <= {mag_reg[30:0], 1'b0};
                    if (bit_reg == 5'd0)
                    begin
                        i1_reg    <= '0;
                        k_reg     <= AW'(1);
                        state_reg <= (point_count_reg == CW'(1)) ? S_IXC : S_SCAN;
                    end
                    else
                        bit_reg <= bit_reg - 5'd1;
                    if (bit_reg == 5'd0)
                    begin
                        // C-style remainder of a negative time is folded back into range.
                        if (rem_ge)
                            tp_reg <= (tneg_reg && (rem_trial != {1'b0, loop_period_reg}))
                                ? loop_period_reg - (rem_trial[PER_W-1:0] - loop_period_reg)
                                : rem_trial[PER_W-1:0] - loop_period_reg;
                        else
                            tp_reg <= (tneg_reg && (rem_trial != '0))
                                ? loop_period_reg - rem_trial[PER_W-1:0]
                                : rem_trial[PER_W-1:0];
                    end
                end
                S_SCAN:
                    state_reg <= S_SCMP;
                S_SCMP:
                begin
                    if (st_rknot <= tp_reg)
                        i1_reg <= k_reg;
                    if (CW'(k_reg) == point_count_reg - CW'(1))
                        state_reg <= S_IXC;
                    else
                    begin
                        k_reg     <= k_reg + AW'(1);
                        state_reg <= S_SCAN;
                    end
                end
                S_IXC:
                begin
                    ix_reg[0] <= (i1_reg != '0) ? i1_reg - AW'(1)
                                                : AW'(point_count_reg - CW'(1));
                    ix_reg[1] <= i1_reg;
                    wrap2_reg <= raw2 >= nn;
                    ix_reg[2] <= AW'((raw2 >= nn) ? raw2 - nn : raw2);
                    wrap3_reg <= raw3 >= nn;
                    if (point_count_reg == CW'(1))
                        ix_reg[3] <= '0;
                    else
                        ix_reg[3] <= AW'((raw3 >= nn) ? raw3 - nn : raw3);
                    fj_reg    <= '0;
                    state_reg <= S_FET;
                end
                S_FET:
                    state_reg <= S_FWAIT;
                S_FWAIT:
                begin
                    pts_reg[fj_reg] <= st_rpoint;
                    kt_reg[fj_reg]  <= st_rknot;
                    fj_reg          <= fj_reg + 2'd1;
                    state_reg       <= (fj_reg == 2'd3) ? S_TCALC : S_FET;
                end
                S_TCALC:
                begin
                    t_reg[0] <= (i1_reg != '0) ? TIME_W'(kt_reg[0])
                                               : TIME_W'(kt_reg[0]) - per40;
                    t_reg[1] <= TIME_W'(kt_reg[1]);
                    t_reg[2] <= TIME_W'(kt_reg[2]) + (wrap2_reg ? per40 : '0);
                    if (point_count_reg == CW'(1))
                        t_reg[3] <= TIME_W'(kt_reg[3]) + per40 + per40;
                    else
                        t_reg[3] <= TIME_W'(kt_reg[3]) + (wrap3_reg ? per40 : '0);
                    step_reg  <= '0;
                    axis_reg  <= '0;
                    state_reg <= S_LSTART;
                end
                S_LSTART, S_LWAIT:
                begin
                    if ((state_reg == S_LSTART) && !skip)
                    begin
                        lstart_reg <= 1'b1;
                        state_reg  <= S_LWAIT;
                    end
                    else if ((state_reg == S_LSTART) || lu_done)
                    begin
                        case (step_reg)
                            3'd0:    a1_reg <= res_val;
                            3'd1:    a2_reg <= res_val;
                            3'd2:    a3_reg <= res_val;
                            3'd3:    b1_reg <= res_val;
                            3'd4:    b2_reg <= res_val;
                            default: pos_reg[axis_reg] <= res_sat;
                        endcase
                        if (step_reg == 3'd5)
                        begin
                            step_reg <= '0;
                            axis_reg <= axis_reg + 2'd1;
                            state_reg <= (axis_reg == 2'd2) ? S_RESP : S_LSTART;
                        end
                        else
                        begin
                            step_reg  <= step_reg + 3'd1;
                            state_reg <= S_LSTART;
                        end
                    end
                end
                S_RESP:
                begin
                    if (out_ready)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    pcr_store #(
        .MAX_POINTS (MAX_POINTS),
        .AW         (AW)
    ) u_store (
        .clk    (clk),
        .we     (st_we),
        .waddr  (AW'(point_count_reg)),
        .wknot  (loop_period_reg),
        .wpoint ({point_z, point_y, point_x}),
        .raddr  (st_raddr),
        .rknot  (st_rknot),
        .rpoint (st_rpoint)
    );

    pcr_lerp u_lerp (
        .clk   (clk),
        .rst_n (rst_n),
        .start (lstart_reg),
        .a     (op_a),
        .b     (op_b),
        .num   (op_num),
        .den   (op_den),
        .done  (lu_done),
        .y     (lu_y)
    );

    assign pos_x  = pos_reg[0];
    assign pos_y  = pos_reg[1];
    assign pos_z  = pos_reg[2];
    assign status = status_reg;

`ifndef SYNTHESIS
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input accepted while a result is pending");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_OK)) |-> (pos_x == 0 && pos_y == 0 && pos_z == 0))
        else $error("non-zero position on an error result");

    a_count_lim: assert property (@(posedge clk) disable iff (!rst_n)
        point_count_reg <= CW'(MAX_POINTS))
        else $error("point count beyond capacity");

    a_unit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        lu_done |-> (state_reg == S_LWAIT))
        else $error("interpolation finished outside its wait state");
`endif
endmodule
`default_nettype wire

>>> test/tb.sv
// Testbench for the periodic Catmull-Rom evaluator: directed rows, then random loops.
`default_nettype none
module tb
    import pcr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  NPTS      = 16;
    localparam int  N_ITEMS   = 1400;
    localparam int  CALM_TAIL = 120;
    localparam int  STALL_LIM = 20000;
    localparam longint SPAN_MAX = (longint'(1) << 36) - 1;
    localparam longint SAT_LIM  = longint'(1) << 61;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        status_t            st;
    } position_t;

    typedef struct {
        req_t        req;
        logic [31:0] dt;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [31:0] qt;
        bit          typed;
        status_t     st;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] req_type = REQ_CLEAR;
    logic [31:0] time_delta = '0;
    logic signed [31:0] point_x = '0;
    logic signed [31:0] point_y = '0;
    logic signed [31:0] point_z = '0;
    logic signed [31:0] eval_time = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [1:0] status;

    periodic_catmull_rom_eval DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .time_delta(time_delta),
        .point_x(point_x), .point_y(point_y), .point_z(point_z),
        .eval_time(eval_time),
        .out_valid(out_valid), .out_ready(out_ready),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .status(status)
    );

    always #5 clk = ~clk;

    // Shadow of the loop held in the block.
    longint knot_at [NPTS];
    longint ctrl_at [3][NPTS];
    int     n_stored;
    longint loop_len;

    position_t   pending_pos[$];
    stim_row_t   rows[$];
    int          errors;
    int          results_seen;
    bit          calm;

    function automatic longint scale_round(longint x, longint num, longint den);
        bit          neg;
        bit [63:0]   ux;
        bit [63:0]   un;
        bit [127:0]  prod;
        bit [127:0]  q;
        bit [127:0]  d;
        neg  = (x < 0) != (num < 0);
        ux   = (x < 0) ? -x : x;
        un   = (num < 0) ? -num : num;
        d    = 128'(den);
        prod = {64'd0, ux} * {64'd0, un} + (d >> 1);
        q    = prod / d;
        if (q > 128'(SAT_LIM))
            q = 128'(SAT_LIM);
        return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic longint blend(longint a, longint b, longint num, longint den);
        longint v;
        v = a + scale_round(b - a, num, den);
        if (v > SAT_LIM)
            v = SAT_LIM;
        if (v < -SAT_LIM)
            v = -SAT_LIM;
        return v;
    endfunction

    function automatic logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // Applies one request to the shadow loop and returns the position it yields.
    function automatic position_t curve_step(stim_row_t r);
        position_t res;
        longint    pos [3];
        longint    tp;
        longint    t [4];
        int        ix [4];
        int        i1;
        int        raw;
        longint    p0, p1, p2, p3, a1, a2, a3, b1, b2;
        res.st = ST_OK;
        pos = '{0, 0, 0};
        if (r.req == REQ_CLEAR) begin
            n_stored = 0;
            loop_len = 0;
        end else if (r.req == REQ_APPEND) begin
            if (n_stored >= NPTS) begin
                res.st = ST_FULL;
            end else begin
                if (n_stored > 0 && loop_len == knot_at[n_stored-1]) begin
                    res.st = ST_DUP;
                end else begin
                    knot_at[n_stored]    = loop_len;
                    ctrl_at[0][n_stored] = longint'($signed(r.px));
                    ctrl_at[1][n_stored] = longint'($signed(r.py));
                    ctrl_at[2][n_stored] = longint'($signed(r.pz));
                    n_stored++;
                end
                loop_len += longint'({32'd0, r.dt});
                if (loop_len > SPAN_MAX)
                    loop_len = SPAN_MAX;
            end
        end else if (r.req == REQ_EVAL) begin
            if (n_stored == 0 || loop_len == 0) begin
                res.st = ST_EMPTY;
            end else begin
                tp = longint'($signed(r.qt)) % loop_len;
                if (tp < 0)
                    tp += loop_len;
                i1 = 0;
                for (int k = 1; k < n_stored; k++)
                    if (knot_at[k] <= tp)
                        i1 = k;
                ix[0] = (i1 > 0) ? i1 - 1 : n_stored - 1;
                t[0]  = (i1 > 0) ? knot_at[ix[0]] : knot_at[ix[0]] - loop_len;
                ix[1] = i1;
                t[1]  = knot_at[i1];
                for (int k = 2; k < 4; k++) begin
                    raw   = i1 + k - 1;
                    ix[k] = raw % n_stored;
                    t[k]  = knot_at[ix[k]] + loop_len * longint'(raw / n_stored);
                end
                for (int ax = 0; ax < 3; ax++) begin
                    p0 = ctrl_at[ax][ix[0]];
                    p1 = ctrl_at[ax][ix[1]];
                    p2 = ctrl_at[ax][ix[2]];
                    p3 = ctrl_at[ax][ix[3]];
                    a1 = (t[1] > t[0]) ? blend(p0, p1, tp - t[0], t[1] - t[0]) : p1;
                    a2 = blend(p1, p2, tp - t[1], t[2] - t[1]);
                    a3 = (t[3] > t[2]) ? blend(p2, p3, tp - t[2], t[3] - t[2]) : p2;
                    b1 = blend(a1, a2, tp - t[0], t[2] - t[0]);
                    b2 = blend(a2, a3, tp - t[1], t[3] - t[1]);
                    pos[ax] = blend(b1, b2, tp - t[1], t[2] - t[1]);
                end
            end
        end
        res.x = clip32(pos[0]);
        res.y = clip32(pos[1]);
        res.z = clip32(pos[2]);
        return res;
    endfunction

    function automatic stim_row_t mk(req_t req, logic [31:0] dt, logic [31:0] px,
                                     logic [31:0] py, logic [31:0] pz, logic [31:0] qt,
                                     bit typed = 1'b0, status_t st = ST_OK);
        stim_row_t r;
        r.req = req; r.dt = dt; r.px = px; r.py = py; r.pz = pz; r.qt = qt;
        r.typed = typed; r.st = st;
        return r;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return 32'($signed($urandom_range(0, 32'h000a0000)) - 32'sh00050000);
            2:       return $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 255)
                                                 : 32'h80000000 + $urandom_range(0, 255);
            default: return 32'($signed($urandom_range(0, 32'h02000000)) - 32'sh01000000);
        endcase
    endfunction

    function automatic logic [31:0] rand_delta();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return $urandom;
            2:       return $urandom_range(1, 16);
            default: return $urandom_range(32'h00001000, 32'h00040000);
        endcase
    endfunction

    // Random loops: clear, a run of appends, then one to four evaluations, with some noise.
    task automatic build_random();
        int n_app;
        int n_ev;
        logic [31:0] span;
        while (rows.size() < N_ITEMS) begin
            rows.push_back(mk(REQ_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom));
            n_app = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 19) : $urandom_range(1, 8);
            span = 0;
            for (int i = 0; i < n_app; i++) begin
                rows.push_back(mk(REQ_APPEND, rand_delta(), rand_coord(), rand_coord(),
                                  rand_coord(), $urandom));
                span += rows[$].dt;
            end
            n_ev = $urandom_range(1, 4);
            for (int i = 0; i < n_ev; i++) begin
                case ($urandom_range(0, 5))
                    0:       rows.push_back(mk(REQ_EVAL, $urandom, $urandom, $urandom,
                                               $urandom, $urandom));
                    1:       rows.push_back(mk(REQ_EVAL, $urandom, $urandom, $urandom,
                                               $urandom, 32'(-$urandom_range(0, 32'h00200000))));
                    default: rows.push_back(mk(REQ_EVAL, $urandom, $urandom, $urandom,
                                               $urandom, $urandom_range(0, 2 * span + 1)));
                endcase
            end
            if ($urandom_range(0, 5) == 0)
                rows.push_back(mk(req_t'(2'd3), $urandom, $urandom, $urandom,
                                  $urandom, $urandom));
        end
    endtask

    // Result checking and the stall watchdog.
    int idle_cycles = 0;
    always @(posedge clk) begin
        position_t want;
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIM) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIM);
            $display("** periodic_catmull_rom_eval: FAILED **");
            $finish;
        end
        if (rst_n && out_valid && out_ready) begin
            results_seen++;
            if (pending_pos.size() == 0) begin
                errors++;
                $display("%0t: result item with none expected: %h %h %h st %0d",
                         $time, pos_x, pos_y, pos_z, status);
            end else begin
                want = pending_pos.pop_front();
                if (pos_x !== want.x || pos_y !== want.y || pos_z !== want.z
                    || status !== want.st) begin
                    errors++;
                    $display("%0t: mismatch expected %h %h %h st %0d, actual %h %h %h st %0d",
                             $time, want.x, want.y, want.z, want.st,
                             pos_x, pos_y, pos_z, status);
                end
            end
        end
    end

    // Receiver: random stall bursts and one long hold-off while the sender keeps offering.
    initial begin
        bit held;
        held = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (!held && results_seen >= 300) begin
                held = 1'b1;
                out_ready = 1'b0;
                repeat (600) @(negedge clk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 13) - 1) @(negedge clk);
            end else begin
                out_ready = 1'b1;
            end
        end
    end

    initial begin
        position_t got;
        stim_row_t r;
        errors = 0;
        results_seen = 0;
        calm = 1'b0;
        n_stored = 0;
        loop_len = 0;

        rows.push_back(mk(REQ_EVAL, 0, 0, 0, 0, 0, 1'b1, ST_EMPTY));
        rows.push_back(mk(REQ_CLEAR, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                          32'hffffffff, 32'hffffffff, 1'b1, ST_OK));
        rows.push_back(mk(req_t'(2'd3), 32'h1234, 1, 2, 3, 4, 1'b1, ST_OK));
        rows.push_back(mk(REQ_APPEND, 32'h00010000, 32'h7fffffff, 32'h80000000, 0, 0));
        rows.push_back(mk(REQ_EVAL, 0, 0, 0, 0, 32'h00008000));
        rows.push_back(mk(REQ_APPEND, 0, 0, 32'hffffffff, 32'h00012345, 0));
        // The knot equals the last one, so the point is dropped but its delta still counts.
        rows.push_back(mk(REQ_APPEND, 32'h00020000, 1, 1, 1, 0, 1'b1, ST_DUP));
        rows.push_back(mk(REQ_APPEND, 32'hffffffff, 32'h80000000, 32'h7fffffff,
                          32'hffffffff, 0));
        rows.push_back(mk(REQ_APPEND, 0, 32'h00030000, 32'hfffd0000, 32'h00000100, 0));
        rows.push_back(mk(REQ_EVAL, 0, 0, 0, 0, 32'h80000000));
        rows.push_back(mk(REQ_EVAL, 0, 0, 0, 0, 32'h7fffffff));
        rows.push_back(mk(REQ_EVAL, 0, 0, 0, 0, 32'h00000000));
        rows.push_back(mk(REQ_EVAL, 0, 0, 0, 0, 32'hffffffff));
        rows.push_back(mk(REQ_CLEAR, 0, 0, 0, 0, 0, 1'b1, ST_OK));
        rows.push_back(mk(REQ_APPEND, 0, 32'h00050000, 32'h00060000, 32'h00070000, 0));
        rows.push_back(mk(REQ_EVAL, 0, 0, 0, 0, 32'h00001000, 1'b1, ST_EMPTY));
        rows.push_back(mk(REQ_CLEAR, 0, 0, 0, 0, 0, 1'b1, ST_OK));
        // Last delta zero: the outer intervals at both ends of the loop have zero length.
        rows.push_back(mk(REQ_APPEND, 32'h00010000, 32'h00010000, 32'hfff00000, 32'h0, 0));
        rows.push_back(mk(REQ_APPEND, 32'h00010000, 32'h00040000, 32'h00020000, 32'h00100000, 0));
        rows.push_back(mk(REQ_APPEND, 0, 32'hfffc0000, 32'h00080000, 32'h00030000, 0));
        rows.push_back(mk(REQ_EVAL, 0, 0, 0, 0, 32'h00004000));
        rows.push_back(mk(REQ_EVAL, 0, 0, 0, 0, 32'h00014000));
        rows.push_back(mk(REQ_EVAL, 0, 0, 0, 0, 32'hfffec000));
        build_random();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < rows.size(); i++) begin
            r = rows[i];
            if (i >= rows.size() - CALM_TAIL)
                calm = 1'b1;
            if (!calm && $urandom_range(0, 3) == 0) begin
                in_valid = 1'b0;
                repeat ($urandom_range(1, 13) - 1) @(negedge clk);
                @(negedge clk);
            end
            in_valid   = 1'b1;
            req_type   = r.req;
            time_delta = r.dt;
            point_x    = r.px;
            point_y    = r.py;
            point_z    = r.pz;
            eval_time  = r.qt;
            do
                @(posedge clk);
            while (!in_ready);
            got = curve_step(r);
            if (r.typed) begin
                got.x = '0;
                got.y = '0;
                got.z = '0;
                got.st = r.st;
            end
            pending_pos.push_back(got);
            @(negedge clk);
        end
        in_valid = 1'b0;

        while (pending_pos.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("** periodic_catmull_rom_eval: PASSED **");
        else
            $display("** periodic_catmull_rom_eval: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire

>>> files.f
sv/pcr_pkg.sv
sv/pcr_lerp.sv
sv/pcr_store.sv
sv/periodic_catmull_rom_eval.sv
test/tb.sv
